// ===== rtl/dmd_pkg.sv =====
// Shared types and constants of the directional maxima detector.
`default_nettype none

package dmd_pkg;

    localparam int DEF_MAX_RADIUS = 8;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_VALUE_BITS = 16;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int THRESHOLD_BITS = 16;
    localparam int RADIUS_BITS    = 4;
    localparam int SIZE_BITS      = 11;

    localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RST = 16'h0000;
    localparam logic [RADIUS_BITS-1:0]    RADIUS_RST    = 4'd1;
    localparam logic [SIZE_BITS-1:0]      WIDTH_RST     = 11'd1024;
    localparam logic [SIZE_BITS-1:0]      HEIGHT_RST    = 11'd1024;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_RADIUS    = 2'd1,
        CFG_WIDTH     = 2'd2,
        CFG_HEIGHT    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic vert;
        logic left;
        logic right;
    } cell_ok_t;

endpackage

`default_nettype wire

// ===== rtl/dmd_bank.sv =====
// One row slot of the line store: one write port, two registered read ports.
`default_nettype none

module dmd_bank #(
    parameter int DEPTH = dmd_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(dmd_pkg::DEF_MAX_WIDTH),
    parameter int DW    = dmd_pkg::DEF_VALUE_BITS
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [DW-1:0] rdata_a,
    output logic      [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dmd_cell.sv =====
// One cell of the comparison chain: holds a left and a lookahead value of the center row.
`default_nettype none

module dmd_cell #(
    parameter int INDEX      = 1,
    parameter int MAX_RADIUS = dmd_pkg::DEF_MAX_RADIUS,
    parameter int VALUE_BITS = dmd_pkg::DEF_VALUE_BITS,
    parameter int RADW       = $clog2(dmd_pkg::DEF_MAX_RADIUS + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         shift,
    input  wire logic        [RADW-1:0]       r,
    input  wire logic signed [VALUE_BITS-1:0] center,
    input  wire logic signed [VALUE_BITS-1:0] above,
    input  wire logic signed [VALUE_BITS-1:0] below,
    input  wire logic signed [VALUE_BITS-1:0] left_in,
    input  wire logic signed [VALUE_BITS-1:0] la_in,
    output logic signed      [VALUE_BITS-1:0] left_out,
    output logic signed      [VALUE_BITS-1:0] la_out,
    output dmd_pkg::cell_ok_t                 ok
);

    logic signed [VALUE_BITS-1:0] left_reg;
    logic signed [VALUE_BITS-1:0] la_reg;
    logic                         act;
    logic                         right_en;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            left_reg <= left_in;
            la_reg   <= la_in;
        end
    end

    assign left_out = left_reg;
    assign la_out   = la_reg;

    // lookahead in this cell is radius minus INDEX columns right of the center
    assign act      = (r >= RADW'(INDEX));
    assign right_en = (r > RADW'(INDEX));

    always_comb
    begin
        ok.vert  = !act || ((center >= above) && (center > below));
        ok.left  = !act || (center >= left_reg);
        ok.right = !right_en || (center > la_reg);
    end

endmodule

`default_nettype wire

// ===== rtl/directional_maxima_detector.sv =====
// Directional local maxima detector over a raster pixel stream.
//
// Pixels enter on in_valid/in_stall in raster order, one beat per pixel.
// Each pixel at row r (r at least radius) yields one result beat on
// out_valid/out_stall: is_maximum for the pixel radius rows above, same
// column, and end_of_frame on the last pixel of the frame. Rows above
// radius give no beat. Configuration is written on cfg_valid/cfg_ready
// (always ready) by register index; the user must write it only while
// the block is idle, which the block does not enforce. Throughput is
// one pixel per cycle unless out_stall holds a result: 2*MAX_RADIUS line
// store banks, two read ports each, are read when a pixel is taken; cells
// hold center row neighbors; results pass the read and output registers.
// When out_stall holds a result, the next pixel still moves into the read
// stage; a further pixel waits with in_stall until the output drains.
// Reset clears the row and column counters and loads the register defaults;
// the line store is not cleared.
`default_nettype none

module directional_maxima_detector #(
    parameter int MAX_RADIUS = dmd_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = dmd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dmd_pkg::DEF_MAX_HEIGHT,
    parameter int VALUE_BITS = dmd_pkg::DEF_VALUE_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [VALUE_BITS-1:0]         pixel_value,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      is_maximum,
    output logic                                      end_of_frame,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [dmd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [dmd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int RING = 2 * MAX_RADIUS;
    localparam int SW   = (RING > 1) ? $clog2(RING) : 1;
    localparam int SAW  = SW + 2;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int RADW = $clog2(MAX_RADIUS + 1);
    localparam int XW0  = (CW > RW) ? CW + 1 : RW + 1;
    localparam int XW   = (XW0 > dmd_pkg::SIZE_BITS) ? XW0 : dmd_pkg::SIZE_BITS;
    localparam int RXW  = (RADW > dmd_pkg::RADIUS_BITS) ? RADW : dmd_pkg::RADIUS_BITS;
    localparam int TXW  = (VALUE_BITS > dmd_pkg::THRESHOLD_BITS) ?
                          VALUE_BITS : dmd_pkg::THRESHOLD_BITS;

    function automatic logic [SW-1:0] slot_wrap(input logic [SAW-1:0] x);
        logic [SAW-1:0] y;
        begin
            y = x;
            if (y >= SAW'(2 * RING))
            begin
                y = y - SAW'(2 * RING);
            end
            if (y >= SAW'(RING))
            begin
                y = y - SAW'(RING);
            end
            return y[SW-1:0];
        end
    endfunction

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (SAW'(s) == SAW'(RING - 1)) ? '0 : s + SW'(1);
    endfunction

    // configuration
    logic [dmd_pkg::THRESHOLD_BITS-1:0] thr_reg;
    logic [dmd_pkg::RADIUS_BITS-1:0]    rad_reg;
    logic [dmd_pkg::SIZE_BITS-1:0]      wid_reg;
    logic [dmd_pkg::SIZE_BITS-1:0]      hgt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= dmd_pkg::THRESHOLD_RST;
            rad_reg <= dmd_pkg::RADIUS_RST;
            wid_reg <= dmd_pkg::WIDTH_RST;
            hgt_reg <= dmd_pkg::HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (dmd_pkg::cfg_index_t'(cfg_index))
                dmd_pkg::CFG_THRESHOLD: thr_reg <= cfg_data[dmd_pkg::THRESHOLD_BITS-1:0];
                dmd_pkg::CFG_RADIUS:    rad_reg <= cfg_data[dmd_pkg::RADIUS_BITS-1:0];
                dmd_pkg::CFG_WIDTH:     wid_reg <= cfg_data[dmd_pkg::SIZE_BITS-1:0];
                dmd_pkg::CFG_HEIGHT:    hgt_reg <= cfg_data[dmd_pkg::SIZE_BITS-1:0];
            endcase
        end
    end

    logic [XW-1:0]   wid_x;
    logic [XW-1:0]   hgt_x;
    logic [XW-1:0]   w;
    logic [XW-1:0]   h;
    logic [RXW-1:0]  rad_x;
    logic [RADW-1:0] r;
    logic [TXW-1:0]  thr_x;
    logic signed [VALUE_BITS-1:0] thr_v;

    assign wid_x = XW'(wid_reg);
    assign hgt_x = XW'(hgt_reg);
    assign rad_x = RXW'(rad_reg);
    assign w = (wid_x == '0) ? XW'(1) : ((wid_x > XW'(MAX_WIDTH))  ? XW'(MAX_WIDTH)  : wid_x);
    assign h = (hgt_x == '0) ? XW'(1) : ((hgt_x > XW'(MAX_HEIGHT)) ? XW'(MAX_HEIGHT) : hgt_x);
    assign r = (rad_x == '0) ? RADW'(1) :
               ((rad_x > RXW'(MAX_RADIUS)) ? RADW'(MAX_RADIUS) : rad_x[RADW-1:0]);
    assign thr_x = TXW'(thr_reg);
    assign thr_v = thr_x[VALUE_BITS-1:0];

    // handshake
    logic s2_valid_reg;
    logic s2_emit_reg;
    logic out_valid_reg;
    logic out_free;
    logic s2_adv;
    logic accept;

    assign out_free = !out_valid_reg || !out_stall;
    assign s2_adv   = s2_valid_reg && (!s2_emit_reg || out_free);
    assign in_stall = s2_valid_reg && !s2_adv;
    assign accept   = in_valid && !in_stall;

    // position counters
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [SW-1:0] slot_reg;
    logic [XW-1:0] col_p;
    logic [XW-1:0] row_p;
    logic [SW-1:0] slot_p;
    logic [XW-1:0] col_next;
    logic [XW-1:0] row_next;
    logic [SW-1:0] slot_next;

    always_comb
    begin
        col_p  = XW'(col_reg);
        row_p  = XW'(row_reg);
        slot_p = slot_reg;
        if (col_p >= w)
        begin
            col_p  = '0;
            row_p  = row_p + XW'(1);
            slot_p = slot_inc(slot_p);
        end
        if (row_p >= h)
        begin
            row_p  = '0;
            slot_p = '0;
        end
    end

    always_comb
    begin
        col_next  = col_p + XW'(1);
        row_next  = row_p;
        slot_next = slot_p;
        if (col_next >= w)
        begin
            col_next  = '0;
            row_next  = row_p + XW'(1);
            slot_next = slot_inc(slot_p);
            if (row_next >= h)
            begin
                row_next  = '0;
                slot_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next[CW-1:0];
            row_reg  <= row_next[RW-1:0];
            slot_reg <= slot_next;
        end
    end

    // read stage
    logic [XW-1:0] r_x;
    logic          emit_d;
    logic          edge_d;
    logic          eof_d;
    logic          s2_edge_reg;
    logic          s2_eof_reg;
    logic [SW-1:0] s2_slot_reg;
    logic [RADW-1:0] s2_r_reg;
    logic signed [VALUE_BITS-1:0] s2_value_reg;

    assign r_x    = XW'(r);
    assign emit_d = (row_p >= r_x);
    assign edge_d = (row_p >= (r_x + r_x)) && (col_p >= r_x) && ((col_p + r_x) < w);
    assign eof_d  = (row_p == (h - XW'(1))) && (col_p == (w - XW'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_emit_reg  <= 1'b0;
        end
        else if (accept)
        begin
            s2_valid_reg <= 1'b1;
            s2_emit_reg  <= emit_d;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_edge_reg  <= edge_d;
            s2_eof_reg   <= eof_d;
            s2_slot_reg  <= slot_p;
            s2_r_reg     <= r;
            s2_value_reg <= pixel_value;
        end
    end

    logic [CW-1:0] addr_a;
    logic [CW-1:0] addr_b;
    logic [XW-1:0] addr_b_x;
    logic [VALUE_BITS-1:0] bank_a [RING];
    logic [VALUE_BITS-1:0] bank_b [RING];

    assign addr_a   = col_p[CW-1:0];
    assign addr_b_x = col_p + r_x;
    assign addr_b   = addr_b_x[CW-1:0];

    for (genvar b = 0; b < RING; b++)
    begin : g_bank
        dmd_bank #(
            .DEPTH (MAX_WIDTH),
            .AW    (CW),
            .DW    (VALUE_BITS)
        ) u_bank (
            .clk     (clk),
            .we      (accept && (SAW'(slot_p) == SAW'(b))),
            .waddr   (addr_a),
            .wdata   (pixel_value),
            .re      (accept),
            .raddr_a (addr_a),
            .raddr_b (addr_b),
            .rdata_a (bank_a[b]),
            .rdata_b (bank_b[b])
        );
    end

    // compare stage
    logic [SW-1:0] cs;
    logic signed [VALUE_BITS-1:0] center;
    logic signed [VALUE_BITS-1:0] la_cur;
    logic signed [VALUE_BITS-1:0] left_ch [MAX_RADIUS + 1];
    logic signed [VALUE_BITS-1:0] la_ch   [MAX_RADIUS + 1];
    dmd_pkg::cell_ok_t            ok      [MAX_RADIUS];
    logic [MAX_RADIUS-1:0] vert_ok;
    logic [MAX_RADIUS-1:0] left_ok;
    logic [MAX_RADIUS-1:0] right_ok;
    logic right_top;
    logic flag;

    assign cs         = slot_wrap(SAW'(s2_slot_reg) + SAW'(RING) - SAW'(s2_r_reg));
    assign center     = bank_a[cs];
    assign la_cur     = bank_b[cs];
    assign left_ch[0] = center;
    assign la_ch[0]   = la_cur;

    for (genvar m = 1; m <= MAX_RADIUS; m++)
    begin : g_cell
        logic [SW-1:0] above_idx;
        logic [SW-1:0] below_idx;
        logic signed [VALUE_BITS-1:0] below_v;

        assign above_idx = slot_wrap(SAW'(s2_slot_reg) + SAW'(2 * RING)
                                     - SAW'(s2_r_reg) - SAW'(m));
        assign below_idx = slot_wrap(SAW'(s2_slot_reg) + SAW'(RING)
                                     - SAW'(s2_r_reg) + SAW'(m));
        assign below_v   = (s2_r_reg == RADW'(m)) ? s2_value_reg : bank_a[below_idx];

        dmd_cell #(
            .INDEX      (m),
            .MAX_RADIUS (MAX_RADIUS),
            .VALUE_BITS (VALUE_BITS),
            .RADW       (RADW)
        ) u_cell (
            .clk      (clk),
            .shift    (s2_adv),
            .r        (s2_r_reg),
            .center   (center),
            .above    (bank_a[above_idx]),
            .below    (below_v),
            .left_in  (left_ch[m-1]),
            .la_in    (la_ch[m-1]),
            .left_out (left_ch[m]),
            .la_out   (la_ch[m]),
            .ok       (ok[m-1])
        );

        assign vert_ok[m-1]  = ok[m-1].vert;
        assign left_ok[m-1]  = ok[m-1].left;
        assign right_ok[m-1] = ok[m-1].right;
    end

    assign right_top = (center > la_cur);
    assign flag = s2_edge_reg && (center >= thr_v) &&
                  ((&vert_ok) || ((&left_ok) && (&right_ok) && right_top));

    // output register
    logic is_max_reg;
    logic eof_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s2_adv && s2_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s2_adv && s2_emit_reg)
        begin
            is_max_reg <= flag;
            eof_reg    <= s2_eof_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign is_maximum   = is_max_reg;
    assign end_of_frame = eof_reg;

    a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !s2_valid_reg |-> !in_stall)
        else $error("input stalled with empty read stage");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s2_valid_reg)
        else $error("accepted beat lost before read stage");

    a_slot_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (SAW'(slot_reg) < SAW'(RING)))
        else $error("row slot outside line store");

    a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_valid_reg && s2_emit_reg))
        else $error("result beat without emitting item");

endmodule

`default_nettype wire
